// File: hdl/mcr_pkg.sv
// Package: shared types and constants of the MIDI channel router.
package mcr_pkg;

   localparam logic [1:0] ACT_BLOCK = 2'd0;
   localparam logic [1:0] ACT_MSG   = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   localparam logic [1:0] KIND_EVENT   = 2'd0;
   localparam logic [1:0] KIND_TRIGGER = 2'd1;
   localparam logic [1:0] KIND_PANIC   = 2'd2;

   localparam logic [1:0] CSR_BASS_CH  = 2'd0;
   localparam logic [1:0] CSR_KICK_CH  = 2'd1;
   localparam logic [1:0] CSR_DELAY    = 2'd2;

   localparam logic [6:0] PANIC_CC_A = 7'd120;
   localparam logic [6:0] PANIC_CC_B = 7'd123;
   localparam logic [4:0] CHANNELS   = 5'd16;

   localparam int ENTRY_W = 17 + 4 + 7 + 7 + 1;

   typedef struct packed {
      logic [16:0] samples;
      logic [3:0]  channel;
      logic [6:0]  note;
      logic [6:0]  velocity;
      logic        is_on;
   } entry_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  status;
      logic [6:0]  data_one;
      logic [6:0]  data_two;
      logic [1:0]  byte_count;
      logic [15:0] pos;
      logic        replaces_last;
      logic [15:0] overflow_total;
      logic        last_result;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN,
      ST_SCAN_END,
      ST_FLUSH_RD,
      ST_FLUSH,
      ST_MSG_OUT
   } state_type;

   function automatic logic [4:0] clamp_channel(input logic [4:0] c);
      if (c == 5'd0) return 5'd1;
      if (c > CHANNELS) return CHANNELS;
      return c;
   endfunction

endpackage

// File: hdl/mcr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module mcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// File: hdl/midi_channel_router_with_delay_queue_top.sv
// Top level: MIDI channel router with a pending store for delayed bass notes.
//
// Beats enter on the req_ channel: the action on req_tuser, block length,
// sample position and a short MIDI message on req_tdata. Results leave on
// rsp_, the kind on rsp_tuser; rsp_tlast marks the last result caused by one
// request beat. Beats that cause no result (clear, dropped kick notes, stored
// bass notes) leave nothing on rsp_. The csr_ channel writes bass_channel (0),
// kick_channel (1) and bass_delay (2) and is always ready.
// A message beat is accepted when the block is idle and the output register
// is free; bar a pending-store overflow, its result is in the output register
// the next cycle; such beats follow one per cycle while the receiver keeps up.
// A block start with pending entries walks them after acceptance: a read
// state, then each entry in turn, then an end state that sends the final due
// entry, held back so that it can carry tlast. Due entries leave, the rest
// are compacted in place. A pending-store overflow sends every entry after a
// read state, then the message itself.
// A stalled receiver holds the output register; the walk and req_tready wait.
// Reset clears counts, state and valid flags; the RAM needs no clearing since
// only entries below the fill count are used. Block length resets to 1.
module midi_channel_router_with_delay_queue_top
   import mcr_pkg::*;
#(
   parameter int PENDING_DEPTH = 32,
   parameter int ACTION_DEPTH  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // block_samples[15:0], sample_pos[31:16], status_byte[39:32],
   // data_one[46:40], data_two[53:47], byte_count[55:54]
   input  logic [55:0] req_tdata,
   // action[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_status[7:0], out_data_one[14:8], out_data_two[21:15],
   // out_byte_count[23:22], out_pos[39:24], replaces_last[40],
   // overflow_total[56:41], zero fill
   output logic [63:0] rsp_tdata,
   // kind[1:0]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int CW = $clog2(PENDING_DEPTH + 1);
   localparam int NW = $clog2(ACTION_DEPTH + 1);
   localparam logic [CW-1:0] PEND_FULL = CW'(PENDING_DEPTH);
   localparam logic [NW-1:0] ACT_FULL  = NW'(ACTION_DEPTH);

   logic [4:0]  bass_ch_ff, kick_ch_ff;
   logic [15:0] delay_ff;
   logic [15:0] block_len_ff, block_len_in;
   logic [CW-1:0] count_ff, count_in;
   logic [NW-1:0] actions_ff, actions_in;
   logic [15:0] ovf_ff, ovf_in;
   state_type   state_ff, state_in;
   logic [CW-1:0] rd_ff, rd_in;
   logic [CW-1:0] wr_ff, wr_in;
   result_type  out_ff, out_in;
   logic        out_vld_ff, out_vld_in;
   result_type  msg_ff, msg_in;
   logic        hold_vld_ff, hold_vld_in;
   logic [15:0] pos_ff, pos_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   entry_type     ram_wdata, ram_rdata;

   mcr_ram #(.WIDTH(ENTRY_W), .DEPTH(PENDING_DEPTH)) u_pend (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // request fields
   logic [1:0]  f_act, f_bc;
   logic [15:0] f_blk, f_pos;
   logic [7:0]  f_st;
   logic [6:0]  f_d1, f_d2;
   assign f_act = req_tuser;
   assign f_blk = req_tdata[15:0];
   assign f_pos = req_tdata[31:16];
   assign f_st  = req_tdata[39:32];
   assign f_d1  = req_tdata[46:40];
   assign f_d2  = req_tdata[53:47];
   assign f_bc  = req_tdata[55:54];

   logic out_free;
   assign out_free   = !out_vld_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign csr_ready  = 1'b1;

   logic acc;
   assign acc = req_tvalid && req_tready;

   // message decode
   logic [1:0]  bc;
   logic [6:0]  d1, d2;
   logic [3:0]  hi;
   logic [4:0]  ch, kick, bass;
   logic        note_any, note_on, is_kick, is_panic, is_bass;
   logic [16:0] target;
   logic [15:0] ovf_bump;

   always_comb begin
      bc       = (f_bc == 2'd0) ? 2'd1 : f_bc;
      d1       = (bc > 2'd1) ? f_d1 : 7'd0;
      d2       = (bc > 2'd2) ? f_d2 : 7'd0;
      hi       = f_st[7:4];
      ch       = (hi == 4'hF) ? 5'd0 : {1'b0, f_st[3:0]} + 5'd1;
      kick     = clamp_channel(kick_ch_ff);
      bass     = clamp_channel(bass_ch_ff);
      note_any = (hi == 4'h9) || (hi == 4'h8);
      note_on  = (hi == 4'h9) && (d2 != 7'd0);
      is_kick  = (ch == kick) && note_any;
      is_panic = (ch == kick) && (hi == 4'hB) && ((d1 == PANIC_CC_A) || (d1 == PANIC_CC_B));
      is_bass  = (ch == bass) && (delay_ff != 16'd0) && note_any;
      target   = {1'b0, f_pos} + {1'b0, delay_ff};
      ovf_bump = (ovf_ff == 16'hFFFF) ? ovf_ff : ovf_ff + 16'd1;
   end

   // pending entry walk
   entry_type   cur;
   logic        due;
   logic [16:0] aged;
   result_type  pend_res;
   assign cur  = ram_rdata;
   assign due  = cur.samples < {1'b0, block_len_ff};
   assign aged = cur.samples - {1'b0, block_len_ff};

   always_comb begin
      pend_res.kind           = KIND_EVENT;
      pend_res.status         = {(cur.is_on ? 4'h9 : 4'h8), cur.channel};
      pend_res.data_one       = cur.note;
      pend_res.data_two       = cur.velocity;
      pend_res.byte_count     = 2'd3;
      pend_res.pos            = (state_ff == ST_FLUSH) ? pos_ff : cur.samples[15:0];
      pend_res.replaces_last  = 1'b0;
      pend_res.overflow_total = ovf_ff;
      pend_res.last_result    = 1'b0;
   end

   // rd_ff leads the entry under test by one
   logic last_rd;
   assign last_rd = rd_ff >= count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc && f_act == ACT_BLOCK && count_ff != '0) state_in = ST_SCAN_RD;
            else if (acc && f_act == ACT_MSG && !is_kick && !is_panic && is_bass
                     && target >= {1'b0, block_len_ff} && count_ff == PEND_FULL)
               state_in = ST_FLUSH_RD;
         end
         ST_SCAN_RD:  state_in = ST_SCAN;
         ST_FLUSH_RD: state_in = ST_FLUSH;
         ST_SCAN:     if (out_free && last_rd) state_in = ST_SCAN_END;
         ST_SCAN_END: if (!hold_vld_ff || out_free) state_in = ST_IDLE;
         ST_FLUSH:    if (out_free && last_rd) state_in = ST_MSG_OUT;
         ST_MSG_OUT:  if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      block_len_in = block_len_ff;
      count_in     = count_ff;
      actions_in   = actions_ff;
      ovf_in       = ovf_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      msg_in       = msg_ff;
      hold_vld_in  = hold_vld_ff;
      pos_in       = pos_ff;
      out_in       = out_ff;
      out_vld_in   = out_vld_ff && !rsp_tready;
      ram_we       = 1'b0;
      ram_waddr    = wr_ff[AW-1:0];
      ram_wdata    = cur;
      ram_raddr    = rd_ff[AW-1:0];

      out_in.kind           = KIND_EVENT;
      out_in.status         = f_st;
      out_in.data_one       = d1;
      out_in.data_two       = d2;
      out_in.byte_count     = bc;
      out_in.pos            = f_pos;
      out_in.replaces_last  = 1'b0;
      out_in.overflow_total = ovf_ff;
      out_in.last_result    = 1'b1;
      if (state_ff != ST_IDLE || !acc) out_in = out_ff;

      unique case (state_ff)
         ST_IDLE: begin
            ram_raddr = '0;
            rd_in     = '0;
            wr_in     = '0;
            if (acc) begin
               unique case (f_act)
                  ACT_CLEAR: begin
                     count_in   = '0;
                     actions_in = '0;
                     ovf_in     = '0;
                  end
                  ACT_BLOCK: begin
                     block_len_in = (f_blk == 16'd0) ? 16'd1 : f_blk;
                     actions_in   = '0;
                  end
                  ACT_MSG: begin
                     if (is_kick) begin
                        if (note_on) begin
                           if (actions_ff < ACT_FULL) begin
                              actions_in  = actions_ff + NW'(1);
                              out_in.kind = KIND_TRIGGER;
                              out_vld_in  = 1'b1;
                           end else begin
                              ovf_in = ovf_bump;
                           end
                        end
                     end else if (is_panic) begin
                        out_in.kind     = KIND_PANIC;
                        out_in.data_one = '0;
                        out_in.data_two = '0;
                        out_vld_in      = 1'b1;
                        if (actions_ff < ACT_FULL) begin
                           actions_in = actions_ff + NW'(1);
                        end else begin
                           ovf_in                = ovf_bump;
                           out_in.overflow_total = ovf_bump;
                           out_in.replaces_last  = 1'b1;
                        end
                     end else if (is_bass) begin
                        if (target < {1'b0, block_len_ff}) begin
                           out_in.pos = target[15:0];
                           out_vld_in = 1'b1;
                        end else if (count_ff < PEND_FULL) begin
                           ram_we             = 1'b1;
                           ram_waddr          = count_ff[AW-1:0];
                           ram_wdata.samples  = target - {1'b0, block_len_ff};
                           ram_wdata.channel  = f_st[3:0];
                           ram_wdata.note     = d1;
                           ram_wdata.velocity = d2;
                           ram_wdata.is_on    = note_on;
                           count_in           = count_ff + CW'(1);
                        end else begin
                           ovf_in = ovf_bump;
                           msg_in = out_in;
                           msg_in.overflow_total = ovf_bump;
                           pos_in = f_pos;
                        end
                     end else begin
                        out_vld_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN_RD, ST_FLUSH_RD: begin
            rd_in     = rd_ff + CW'(1);
            ram_raddr = rd_ff[AW-1:0];
         end
         ST_SCAN: begin
            ram_raddr = rd_ff[AW-1:0] - AW'(1);
            if (out_free) begin
               ram_raddr = rd_ff[AW-1:0];
               if (due) begin
                  // a due entry waits in msg_ff until the next due one or the walk's end
                  if (hold_vld_ff) begin
                     out_in     = msg_ff;
                     out_vld_in = 1'b1;
                  end
                  msg_in      = pend_res;
                  hold_vld_in = 1'b1;
               end else begin
                  ram_we            = 1'b1;
                  ram_wdata.samples = aged;
                  wr_in             = wr_ff + CW'(1);
               end
               rd_in = rd_ff + CW'(1);
               if (last_rd) begin
                  count_in = due ? wr_ff : wr_ff + CW'(1);
               end
            end
         end
         ST_SCAN_END: begin
            if (hold_vld_ff && out_free) begin
               out_in             = msg_ff;
               out_in.last_result = 1'b1;
               out_vld_in         = 1'b1;
               hold_vld_in        = 1'b0;
            end
         end
         ST_FLUSH: begin
            ram_raddr = rd_ff[AW-1:0] - AW'(1);
            if (out_free) begin
               ram_raddr  = rd_ff[AW-1:0];
               out_in     = pend_res;
               out_vld_in = 1'b1;
               rd_in      = rd_ff + CW'(1);
               if (last_rd) count_in = '0;
            end
         end
         ST_MSG_OUT: begin
            if (out_free) begin
               out_in     = msg_ff;
               out_vld_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bass_ch_ff   <= 5'd1;
         kick_ch_ff   <= 5'd10;
         delay_ff     <= '0;
         block_len_ff <= 16'd1;
         count_ff     <= '0;
         actions_ff   <= '0;
         ovf_ff       <= '0;
         state_ff     <= ST_IDLE;
         rd_ff        <= '0;
         wr_ff        <= '0;
         out_vld_ff   <= 1'b0;
         hold_vld_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_BASS_CH: bass_ch_ff <= csr_wdata[4:0];
               CSR_KICK_CH: kick_ch_ff <= csr_wdata[4:0];
               CSR_DELAY:   delay_ff   <= csr_wdata;
               default: ;
            endcase
         end
         block_len_ff <= block_len_in;
         count_ff     <= count_in;
         actions_ff   <= actions_in;
         ovf_ff       <= ovf_in;
         state_ff     <= state_in;
         rd_ff        <= rd_in;
         wr_ff        <= wr_in;
         out_vld_ff   <= out_vld_in;
         hold_vld_ff  <= hold_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      msg_ff <= msg_in;
      pos_ff <= pos_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tlast  = out_ff.last_result;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {7'd0, out_ff.overflow_total, out_ff.replaces_last, out_ff.pos,
                        out_ff.byte_count, out_ff.data_two, out_ff.data_one,
                        out_ff.status};
endmodule
